// ===== hw/rtl/maps_pkg.sv =====
// Shared types and codes for the motor alternating pulse sequencer.
// No dependencies; imported by every module of the block.
package maps_pkg;

	// Width of the elapsed-time arithmetic (phase start time register)
	localparam int TIME_W = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_POWER    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TIME     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TIME       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_BIAS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_ENABLE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LEVEL    = 3'd5;

	// Command codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_ON   = 2'd1;
	localparam logic [1:0] CMD_OFF  = 2'd2;

	// Action codes
	localparam logic [1:0] ACT_DRIVE = 2'd0;
	localparam logic [1:0] ACT_BRAKE = 2'd1;
	localparam logic [1:0] ACT_COAST = 2'd2;

	// Sequencer phase, one-hot
	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_FWD  = 5'b00010,
		PH_GAP1 = 5'b00100,
		PH_REV  = 5'b01000,
		PH_GAP2 = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0]        drive_power;
		logic [15:0]       pulse_time;
		logic [15:0]       gap_time;
		logic signed [8:0] direction_bias;
		logic              brake_enable;
		logic [7:0]        brake_level;
	} cfg_t;

	typedef struct packed {
		logic              running;
		phase_t            phase;
		logic [TIME_W-1:0] start_time;
	} seq_state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic signed [8:0] drive_level;
		logic [7:0]        brake_duty;
	} result_t;

endpackage

// ===== hw/rtl/motor_alternating_pulse_sequencer_core.sv =====
// Top level of the motor alternating pulse sequencer.
// Depends on maps_pkg, maps_cfg_regs and maps_step.
//
// Usage:
//   Slave stream s_*: one command word per transfer. s_tuser carries the
//   command (tick, turn on, turn off), s_tdata the millisecond timestamp.
//   Master stream m_*: one motor command word at each phase change and each turn-off.
//   m_tuser carries the action, m_tdata the signed drive level and duty.
//   Config channel cfg_*: register index and data, always ready; write only
//   while no command word is in flight.
// Timing:
//   A command is registered in the input register and evaluated there against
//   the sequencer state; its result is loaded into the output register as the
//   word retires. One command per cycle is sustained unless a word with a result
//   meets a stalled, full output; the phase/start-time and step logic loop sets that figure.
// Reset:
//   arst_n clears the pipeline, puts the sequencer off and idle and loads
//   the default configuration.
// Backpressure:
//   While m_tready is low a waiting result holds in the output register; the
//   input stage keeps taking words until it holds one that produces a result.
module motor_alternating_pulse_sequencer_core import maps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Command stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [31:0] now_ms
	input  logic [1:0]            s_tuser,   // [1:0] command
	// Motor command stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // [8:0] drive_level, [16:9] brake_duty, rest zero
	output logic [1:0]            m_tuser,   // [1:0] action
	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg;
	seq_state_t  state_q;
	seq_state_t  state_nxt;
	logic        emit;
	result_t     res;

	logic        valid_s1;
	logic [1:0]  command_s1;
	logic [31:0] now_s1;
	logic        adv_s1;

	logic        out_valid_q;
	result_t     out_q;

	assign cfg_ready = 1'b1;

	maps_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	maps_step u_step (
		.cfg     (cfg),
		.cur     (state_q),
		.command (command_s1),
		.now_ms  (now_s1),
		.nxt     (state_nxt),
		.emit    (emit),
		.res     (res)
	);

	// Stage 1 retires when its result has room, or when it has no result
	assign adv_s1   = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1 <= s_tuser;
			now_s1     <= s_tdata;
		end
	end

	// Sequencer state commits as each word retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.running    <= 1'b0;
			state_q.phase      <= PH_IDLE;
			state_q.start_time <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.action;
	assign m_tdata  = {7'd0, out_q.brake_duty, out_q.drive_level};

endmodule

// ===== hw/rtl/maps_cfg_regs.sv =====
// Configuration register file of the pulse sequencer.
// Depends on maps_pkg for register indexes and the cfg_t struct.
module maps_cfg_regs import maps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_power    <= 8'd90;
			cfg_q.pulse_time     <= 16'd25;
			cfg_q.gap_time       <= 16'd30;
			cfg_q.direction_bias <= 9'sd0;
			cfg_q.brake_enable   <= 1'b0;
			cfg_q.brake_level    <= 8'd200;
		end else if (wr_en) begin
			case (wr_index)
				REG_DRIVE_POWER:    cfg_q.drive_power    <= wr_data[7:0];
				REG_PULSE_TIME:     cfg_q.pulse_time     <= wr_data[15:0];
				REG_GAP_TIME:       cfg_q.gap_time       <= wr_data[15:0];
				REG_DIRECTION_BIAS: cfg_q.direction_bias <= $signed(wr_data[8:0]);
				REG_BRAKE_ENABLE:   cfg_q.brake_enable   <= wr_data[0];
				REG_BRAKE_LEVEL:    cfg_q.brake_level    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/maps_step.sv =====
// Next-state and result logic for one command word of the pulse sequencer.
// Purely combinational; depends on maps_pkg.
module maps_step import maps_pkg::*; (
	input  cfg_t            cfg,
	input  seq_state_t      cur,
	input  logic [1:0]      command,
	input  logic [31:0]     now_ms,
	output seq_state_t      nxt,
	output logic            emit,
	output result_t         res
);

	logic [TIME_W-1:0] now_t;
	logic [TIME_W-1:0] elapsed;
	logic              pulse_done;
	logic              gap_done;
	logic [8:0]        bias_fwd;
	logic [8:0]        bias_rev;
	logic [9:0]        sum_fwd;
	logic [9:0]        sum_rev;
	logic [7:0]        lvl_fwd;
	logic [7:0]        lvl_rev;
	result_t           res_fwd;
	result_t           res_rev;
	result_t           res_gap;
	result_t           res_coast;

	// Wrapping elapsed time against the phase timers
	assign now_t      = TIME_W'(now_ms);
	assign elapsed    = now_t - cur.start_time;
	assign pulse_done = elapsed >= TIME_W'(cfg.pulse_time);
	assign gap_done   = elapsed >= TIME_W'(cfg.gap_time);

	// Biased levels, clamped to 255; the most negative bias gives magnitude 256
	assign bias_fwd = cfg.direction_bias[8] ? 9'd0 : $unsigned(cfg.direction_bias);
	assign bias_rev = cfg.direction_bias[8] ? 9'(~$unsigned(cfg.direction_bias) + 9'd1) : 9'd0;
	assign sum_fwd  = {2'b00, cfg.drive_power} + {1'b0, bias_fwd};
	assign sum_rev  = {2'b00, cfg.drive_power} + {1'b0, bias_rev};
	assign lvl_fwd  = (sum_fwd > 10'd255) ? 8'd255 : sum_fwd[7:0];
	assign lvl_rev  = (sum_rev > 10'd255) ? 8'd255 : sum_rev[7:0];

	// Candidate results
	always_comb begin
		res_fwd   = '{action: ACT_DRIVE, drive_level: $signed({1'b0, lvl_fwd}), brake_duty: 8'd0};
		res_rev   = '{action: ACT_DRIVE,
			drive_level: $signed(9'(~{1'b0, lvl_rev} + 9'd1)), brake_duty: 8'd0};
		res_coast = '{action: ACT_COAST, drive_level: 9'sd0, brake_duty: 8'd0};
		res_gap   = cfg.brake_enable
			? result_t'{action: ACT_BRAKE, drive_level: 9'sd0, brake_duty: cfg.brake_level}
			: res_coast;
	end

	// Command decode and phase advance
	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = res_coast;
		case (command)
			CMD_ON: begin
				nxt.running = 1'b1;
				nxt.phase   = PH_IDLE;
			end
			CMD_OFF: begin
				nxt.running = 1'b0;
				nxt.phase   = PH_IDLE;
				emit        = 1'b1;
			end
			CMD_TICK: begin
				if (cur.running) begin
					case (cur.phase)
						PH_FWD: begin
							emit      = pulse_done;
							res       = res_gap;
							nxt.phase = PH_GAP1;
						end
						PH_GAP1: begin
							emit      = gap_done;
							res       = res_rev;
							nxt.phase = PH_REV;
						end
						PH_REV: begin
							emit      = pulse_done;
							res       = res_gap;
							nxt.phase = PH_GAP2;
						end
						PH_GAP2: begin
							emit      = gap_done;
							res       = res_fwd;
							nxt.phase = PH_FWD;
						end
						default: begin
							emit      = 1'b1;
							res       = res_fwd;
							nxt.phase = PH_FWD;
						end
					endcase
					// Phase only moves when its time is up
					if (emit) begin
						nxt.start_time = now_t;
					end else begin
						nxt.phase = cur.phase;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/motor_command_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for motor_alternating_pulse_sequencer_core: mirrors the sequencer and
// its registers, predicts each motor command word and checks the master stream.
// Depends on maps_pkg only.
module motor_command_checker import maps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [31:0] now_ms
	input  logic [1:0]            s_tuser,   // [1:0] command
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [23:0]           m_tdata,   // [8:0] drive_level, [16:9] brake_duty
	input  logic [1:0]            m_tuser,   // [1:0] action
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    error_count,
	output int                    pending_count
);

	cfg_t       regs;
	seq_state_t seq;
	result_t    motor_cmd_q[$];

	function automatic logic [7:0] clamp_level(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	// Forward level uses a positive bias, reverse level the magnitude of a negative one
	function automatic result_t drive_command(input logic reverse);
		int      bias;
		int      power;
		int      lvl;
		result_t r;
		r = '0;
		bias = $signed(regs.direction_bias);
		power = regs.drive_power;
		if (reverse)
			lvl = -int'(clamp_level(power + (bias < 0 ? -bias : 0)));
		else
			lvl = int'(clamp_level(power + (bias > 0 ? bias : 0)));
		r.action = ACT_DRIVE;
		r.drive_level = lvl[8:0];
		return r;
	endfunction

	function automatic result_t gap_command();
		result_t r;
		r = '0;
		if (regs.brake_enable) begin
			r.action = ACT_BRAKE;
			r.brake_duty = regs.brake_level;
		end else begin
			r.action = ACT_COAST;
		end
		return r;
	endfunction

	// Advance the mirrored sequencer by one command; returns 1 when a word is due
	function automatic logic next_motor_command(input logic [1:0] cmd,
			input logic [31:0] now_ms, output result_t res);
		logic [31:0] elapsed;
		logic        fire;
		res = '0;
		fire = 1'b0;
		elapsed = now_ms - seq.start_time;
		case (cmd)
			CMD_ON: begin
				seq.running = 1'b1;
				seq.phase = PH_IDLE;
			end
			CMD_OFF: begin
				seq.running = 1'b0;
				seq.phase = PH_IDLE;
				res.action = ACT_COAST;
				fire = 1'b1;
			end
			CMD_TICK: begin
				if (seq.running) begin
					case (seq.phase)
						PH_FWD: if (elapsed >= regs.pulse_time) begin
							res = gap_command();
							seq.phase = PH_GAP1;
							fire = 1'b1;
						end
						PH_GAP1: if (elapsed >= regs.gap_time) begin
							res = drive_command(1'b1);
							seq.phase = PH_REV;
							fire = 1'b1;
						end
						PH_REV: if (elapsed >= regs.pulse_time) begin
							res = gap_command();
							seq.phase = PH_GAP2;
							fire = 1'b1;
						end
						PH_GAP2: if (elapsed >= regs.gap_time) begin
							res = drive_command(1'b0);
							seq.phase = PH_FWD;
							fire = 1'b1;
						end
						default: begin
							res = drive_command(1'b0);
							seq.phase = PH_FWD;
							fire = 1'b1;
						end
					endcase
					if (fire)
						seq.start_time = now_ms;
				end
			end
			default: ;
		endcase
		return fire;
	endfunction

	// Watch all three channels; inputs are predicted before outputs are checked
	always @(posedge clk or negedge arst_n) begin : watch
		result_t predicted;
		result_t want;
		if (!arst_n) begin
			regs.drive_power = 8'd90;
			regs.pulse_time = 16'd25;
			regs.gap_time = 16'd30;
			regs.direction_bias = 9'sd0;
			regs.brake_enable = 1'b0;
			regs.brake_level = 8'd200;
			seq.running = 1'b0;
			seq.phase = PH_IDLE;
			seq.start_time = '0;
			motor_cmd_q.delete();
			pending_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DRIVE_POWER:    regs.drive_power = cfg_data[7:0];
					REG_PULSE_TIME:     regs.pulse_time = cfg_data;
					REG_GAP_TIME:       regs.gap_time = cfg_data;
					REG_DIRECTION_BIAS: regs.direction_bias = cfg_data[8:0];
					REG_BRAKE_ENABLE:   regs.brake_enable = cfg_data[0];
					REG_BRAKE_LEVEL:    regs.brake_level = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (next_motor_command(s_tuser, s_tdata, predicted))
					motor_cmd_q.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				if (motor_cmd_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected word, expected none, got action %0d data %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = motor_cmd_q.pop_front();
					if (m_tuser !== want.action) begin
						error_count++;
						$display("%0t: action mismatch, expected %0d, got %0d",
							$time, want.action, m_tuser);
					end
					if (m_tdata[8:0] !== want.drive_level) begin
						error_count++;
						$display("%0t: drive_level mismatch, expected %0d, got %0d",
							$time, want.drive_level, $signed(m_tdata[8:0]));
					end
					if (m_tdata[16:9] !== want.brake_duty) begin
						error_count++;
						$display("%0t: brake_duty mismatch, expected %0d, got %0d",
							$time, want.brake_duty, m_tdata[16:9]);
					end
					if (m_tdata[23:17] !== 7'd0) begin
						error_count++;
						$display("%0t: tdata padding mismatch, expected 0, got %h",
							$time, m_tdata[23:17]);
					end
				end
			end
			pending_count = motor_cmd_q.size();
		end
	end

endmodule

// ===== tb/motor_alternating_pulse_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
// Top of the sequencer testbench: clock, reset, command and register stimulus,
// output stalls and the verdict. Depends on maps_pkg, the core and motor_command_checker.
module motor_alternating_pulse_sequencer_core_tb;
	import maps_pkg::*;

	localparam logic [1:0] CMD_RESERVED = 2'd3;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 80;
	localparam int PHASES        = 12;
	localparam int WORDS_PER_PHASE = 120;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // [31:0] now_ms
	logic [1:0]            s_tuser = '0;   // [1:0] command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;        // [8:0] drive_level, [16:9] brake_duty
	logic [1:0]            m_tuser;        // [1:0] action
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int          error_count;
	int          pending_count;
	bit          no_idle = 1'b0;
	bit          hold_off_req = 1'b0;
	logic [31:0] sim_ms = '0;
	logic [15:0] cur_pulse = 16'd25;
	logic [15:0] cur_gap = 16'd30;

	motor_alternating_pulse_sequencer_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	motor_command_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .error_count(error_count), .pending_count(pending_count)
	);

	always #10 clk = ~clk;

	// Send one command word, sometimes with a random gap in front of it
	task automatic send_word(input logic [1:0] cmd, input logic [31:0] stamp);
		int gap;
		if (!no_idle && $urandom_range(0, 99) < 23) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= stamp;
		do @(posedge clk); while (!s_tready);
	endtask

	// Tick with time steps that often land right on a phase boundary
	task automatic tick_step();
		logic [31:0] span;
		span = (cur_pulse > cur_gap ? cur_pulse : cur_gap) + 3;
		case ($urandom_range(0, 5))
			0: ;
			1: sim_ms += cur_pulse;
			2: sim_ms += cur_gap;
			3: sim_ms += cur_pulse - 1;
			4: sim_ms += cur_gap + 1;
			default: sim_ms += $urandom_range(0, span);
		endcase
		send_word(CMD_TICK, sim_ms);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input logic [7:0] power, input logic [15:0] pulse,
			input logic [15:0] gap, input logic [8:0] bias, input logic brake,
			input logic [7:0] level);
		write_reg(REG_DRIVE_POWER, {8'd0, power});
		write_reg(REG_PULSE_TIME, pulse);
		write_reg(REG_GAP_TIME, gap);
		write_reg(REG_DIRECTION_BIAS, {7'd0, bias});
		write_reg(REG_BRAKE_ENABLE, {15'd0, brake});
		write_reg(REG_BRAKE_LEVEL, {8'd0, level});
		cfg_valid <= 1'b0;
		cur_pulse = pulse;
		cur_gap = gap;
	endtask

	function automatic logic [15:0] random_duration();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 40));
	endfunction

	// Stop offering, wait for every expected word, then let in-flight words settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed tick runs, plus noise: jumps, restarts, stops, reserved codes
	task automatic run_random(input int count);
		int r;
		send_word(CMD_ON, sim_ms);
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				tick_step();
			end else if (r < 85) begin
				sim_ms = $urandom();
				send_word(CMD_TICK, sim_ms);
			end else if (r < 90) begin
				send_word(CMD_ON, $urandom());
			end else if (r < 94) begin
				send_word(CMD_OFF, $urandom());
			end else begin
				send_word(CMD_RESERVED, $urandom());
			end
		end
	endtask

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int held;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(posedge clk);
					held++;
				end
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 23);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: power 90, pulse 25, gap 30, coast in gaps
		send_word(CMD_TICK, 32'd0);             // tick while off
		send_word(CMD_RESERVED, 32'd0);         // ignored code
		send_word(CMD_OFF, 32'd0);              // coast even while off
		send_word(CMD_ON, 32'd0);
		send_word(CMD_TICK, 32'd100);           // forward pulse starts
		send_word(CMD_TICK, 32'd124);           // one short of the pulse
		send_word(CMD_TICK, 32'd125);           // first gap
		send_word(CMD_TICK, 32'd155);           // reverse pulse
		send_word(CMD_TICK, 32'd180);           // second gap
		send_word(CMD_TICK, 32'd209);
		send_word(CMD_TICK, 32'd210);           // forward again
		send_word(CMD_RESERVED, 32'hFFFF_FFFF);
		send_word(CMD_ON, 32'hFFFF_FFFF);       // restart from idle
		send_word(CMD_TICK, 32'hFFFF_FFF0);
		send_word(CMD_TICK, 32'h0000_0009);     // elapsed wraps through zero
		send_word(CMD_TICK, 32'hFFFF_FFFF);
		send_word(CMD_OFF, 32'h5555_AAAA);
		send_word(CMD_TICK, 32'hAAAA_5555);     // off again, nothing
		drain();

		sim_ms = 32'd1000;
		for (k = 0; k < PHASES; k++) begin
			case (k)
				0: begin
					// most negative bias pattern, zero times, full brake; also the stall test
					apply_settings(8'd0, 16'd0, 16'd0, 9'h100, 1'b1, 8'd255);
					hold_off_req = 1'b1;
				end
				1: apply_settings(8'd255, 16'hFFFF, 16'hFFFF, 9'd255, 1'b0, 8'd0);
				2: begin
					apply_settings(8'd200, 16'd3, 16'd5, 9'd100, 1'b1, 8'd128);
					no_idle = 1'b1;
				end
				3: apply_settings(8'd10, 16'd1, 16'd0, 9'h1EC, 1'b0, 8'd77);
				default: apply_settings(8'($urandom_range(0, 255)), random_duration(),
					random_duration(), 9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)));
			endcase
			run_random(WORDS_PER_PHASE);
			drain();
			no_idle = 1'b0;
		end

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
